// ===== hdl/captive_dns_responder_macros.svh =====
`ifndef CAPTIVE_DNS_RESPONDER_MACROS_SVH
`define CAPTIVE_DNS_RESPONDER_MACROS_SVH

// implication checked in the same cycle
`define CDR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("captive_dns_responder check failed");

// implication checked in the next cycle
`define CDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("captive_dns_responder check failed");

`endif

// ===== hdl/cdr_pkg.sv =====
`default_nettype none

package cdr_pkg;

	localparam int HDR_LEN = 12;
	localparam int HDR_IDX_W = 4;
	localparam int POS_W = 5;

	localparam logic [HDR_IDX_W-1:0] LAST_HDR_IDX = HDR_IDX_W'(HDR_LEN - 1);

	localparam logic [POS_W-1:0] POS_HDR_LEN = POS_W'(HDR_LEN);
	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
	localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(11);
	localparam logic [POS_W-1:0] POS_HDR_ANS_LAST = POS_W'(27);
	localparam logic [POS_W-1:0] POS_ECHO_LAST = POS_W'(0);
	localparam logic [POS_W-1:0] POS_ECHO_ANS_LAST = POS_W'(16);

	localparam logic [7:0] QR_MASK = 8'h80;
	localparam logic [7:0] RA_CLR_MASK = 8'h7F;
	localparam logic [7:0] QDCOUNT_ONE = 8'h01;

	// pointer c00c, type a, class in, ttl 600, rdlength 4
	localparam logic [95:0] ANS_FIXED = 96'hC00C_0001_0001_0000_0258_0004;

	typedef enum logic [2:0] {
		PH_COLLECT = 3'b001,
		PH_ECHO    = 3'b010,
		PH_DROP    = 3'b100
	} phase_t;

	typedef struct packed {
		logic       vld;
		logic       hdr;
		logic       ans;
		logic [7:0] data;
	} job_t;

	typedef struct packed {
		logic             job_valid;
		logic             busy;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] last_pos;
	} emit_status_t;

	function automatic logic [7:0] answer_byte(input logic [3:0] idx, input logic [31:0] ip);
		logic [7:0] b;
		if (idx < 4'(HDR_LEN)) begin
			b = ANS_FIXED[8*(11 - int'(idx)) +: 8];
		end else begin
			b = ip[8*(15 - int'(idx)) +: 8];
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/captive_dns_responder.sv =====
// channel  dir  handshake            payload
// request  in   in_valid, in_stall   in_byte, in_last
// reply    out  out_valid, out_stall out_byte, out_last
// config   in   cfg_wr_en            cfg_wr_data (answer address)
//
// one request byte per cycle in every packet phase while in_stall is low
// a passing 12th header byte stalls the request side until its reply header (and answer, if also last) is sent
// the last byte of an echoed request stalls it while the burst sequencer sends that byte and the answer
// output register: out_stall freezes it, bursts pause and resume in place
// reset clears packet phase, header count, pending burst, reply valid and address
`default_nettype none

`include "captive_dns_responder_macros.svh"

module captive_dns_responder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             out_last,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);
	import cdr_pkg::*;

	logic                 accept;
	logic [31:0]          answer_ip_q;
	logic [HDR_IDX_W-1:0] hdr_rd_idx;
	logic [7:0]           hdr_rd_byte;
	job_t                 new_job;
	emit_status_t         status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_ip_q <= '0;
		end else if (cfg_wr_en) begin
			answer_ip_q <= cfg_wr_data;
		end
	end

	assign in_stall = status.busy;
	assign accept = in_valid && !in_stall;

	cdr_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.in_last (in_last),
		.rd_idx  (hdr_rd_idx),
		.rd_byte (hdr_rd_byte),
		.new_job (new_job)
	);

	cdr_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.new_job    (new_job),
		.hdr_byte   (hdr_rd_byte),
		.answer_ip  (answer_ip_q),
		.out_stall  (out_stall),
		.hdr_rd_idx (hdr_rd_idx),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.status     (status)
	);

	// a held request always means a reply byte is waiting next cycle
	`CDR_ASSERT_NEXT(a_stall_has_reply, clk, arst_n, in_stall, out_valid)
	// burst position only advances inside a pending burst
	`CDR_ASSERT_SAME(a_pos_in_job, clk, arst_n, status.pos != '0, status.job_valid)
	// burst position never runs past its final byte
	`CDR_ASSERT_SAME(a_pos_bound, clk, arst_n, status.job_valid, status.pos <= status.last_pos)

endmodule

`default_nettype wire

// ===== hdl/cdr_parse.sv =====
`default_nettype none

module cdr_parse (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [7:0]                    in_byte,
	input  wire logic                          in_last,
	input  wire logic [cdr_pkg::HDR_IDX_W-1:0] rd_idx,
	output logic [7:0]                         rd_byte,
	output cdr_pkg::job_t                      new_job
);
	import cdr_pkg::*;

	logic [7:0]           hdr_store [HDR_LEN];
	logic [HDR_IDX_W-1:0] idx_q;
	logic [HDR_IDX_W-1:0] idx_d;
	phase_t               phase_q;
	phase_t               phase_d;
	logic                 wr_en;
	logic                 hdr_pass;

	// byte 11 is the incoming one when the check runs
	assign hdr_pass = (hdr_store[2][7:3] == 5'd0) && (hdr_store[4] == 8'd0) &&
		(hdr_store[5] == QDCOUNT_ONE) && (hdr_store[6] == 8'd0) && (hdr_store[7] == 8'd0) &&
		(hdr_store[8] == 8'd0) && (hdr_store[9] == 8'd0) && (hdr_store[10] == 8'd0) &&
		(in_byte == 8'd0);

	always_comb begin
		new_job = '0;
		idx_d = idx_q;
		phase_d = phase_q;
		wr_en = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_COLLECT: begin
					if (idx_q < HDR_IDX_W'(HDR_LEN)) begin
						wr_en = 1'b1;
						idx_d = idx_q + HDR_IDX_W'(1);
					end
					if (idx_q == LAST_HDR_IDX) begin
						if (hdr_pass) begin
							new_job.vld = 1'b1;
							new_job.hdr = 1'b1;
							new_job.ans = in_last;
							phase_d = PH_ECHO;
						end else begin
							phase_d = PH_DROP;
						end
					end
				end
				PH_ECHO: begin
					new_job.vld = 1'b1;
					new_job.ans = in_last;
					new_job.data = in_byte;
				end
				default: begin
				end
			endcase
			if (in_last) begin
				idx_d = '0;
				phase_d = PH_COLLECT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			phase_q <= PH_COLLECT;
		end else begin
			idx_q <= idx_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hdr_store[idx_q] <= in_byte;
		end
	end

	// reply header view: qr set, ra cleared, ancount from qdcount
	always_comb begin
		case (rd_idx)
			4'd2: rd_byte = hdr_store[2] | QR_MASK;
			4'd3: rd_byte = hdr_store[3] & RA_CLR_MASK;
			4'd6: rd_byte = hdr_store[4];
			4'd7: rd_byte = hdr_store[5];
			default: begin
				if (rd_idx < HDR_IDX_W'(HDR_LEN)) begin
					rd_byte = hdr_store[rd_idx];
				end else begin
					rd_byte = 8'd0;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/cdr_emit.sv =====
`default_nettype none

module cdr_emit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cdr_pkg::job_t                 new_job,
	input  wire logic [7:0]                    hdr_byte,
	input  wire logic [31:0]                   answer_ip,
	input  wire logic                          out_stall,
	output logic [cdr_pkg::HDR_IDX_W-1:0]      hdr_rd_idx,
	output logic                               out_valid,
	output logic [7:0]                         out_byte,
	output logic                               out_last,
	output cdr_pkg::emit_status_t              status
);
	import cdr_pkg::*;

	job_t             job_s1;
	logic             job_valid_s1;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] last_pos;
	logic [POS_W-1:0] ans_pos;
	logic [7:0]       ans_byte;
	logic [7:0]       sel_byte;
	logic             load_ok;
	logic             take;
	logic             final_take;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	always_comb begin
		if (job_s1.hdr) begin
			last_pos = job_s1.ans ? POS_HDR_ANS_LAST : POS_HDR_LAST;
			ans_pos = pos_q - POS_HDR_LEN;
		end else begin
			last_pos = job_s1.ans ? POS_ECHO_ANS_LAST : POS_ECHO_LAST;
			ans_pos = pos_q - POS_ONE;
		end
	end

	assign hdr_rd_idx = pos_q[HDR_IDX_W-1:0];
	assign ans_byte = answer_byte(ans_pos[3:0], answer_ip);

	always_comb begin
		if (job_s1.hdr) begin
			sel_byte = (pos_q < POS_HDR_LEN) ? hdr_byte : ans_byte;
		end else begin
			sel_byte = (pos_q == '0) ? job_s1.data : ans_byte;
		end
	end

	assign load_ok = !out_valid_q || !out_stall;
	assign take = job_valid_s1 && load_ok;
	assign final_take = take && (pos_q == last_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (new_job.vld) begin
				job_valid_s1 <= 1'b1;
				pos_q <= '0;
			end else if (final_take) begin
				job_valid_s1 <= 1'b0;
				pos_q <= '0;
			end else if (take) begin
				pos_q <= pos_q + POS_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (new_job.vld) begin
			job_s1 <= new_job;
		end
		if (take) begin
			out_byte_q <= sel_byte;
			out_last_q <= final_take && job_s1.ans;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	assign status.job_valid = job_valid_s1;
	assign status.busy = job_valid_s1 && !final_take;
	assign status.pos = pos_q;
	assign status.last_pos = last_pos;

endmodule

`default_nettype wire

// ===== verif/tb_captive_dns_responder.sv =====
`default_nettype none

module tb_captive_dns_responder;
	timeunit 1ns;
	timeprecision 1ps;

	import cdr_pkg::*;

	localparam logic [7:0] QR_BIT    = 8'h80;
	localparam logic [7:0] RA_CLEAR  = 8'h7F;
	localparam int         SETTLE    = 40;
	localparam int         DRAIN_MAX = 20000;

	// pointer, type a, class in, ttl 600, rdlength 4
	localparam logic [7:0] ANSWER_PREFIX [12] = '{
		8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
		8'h00, 8'h00, 8'h02, 8'h58, 8'h00, 8'h04
	};

	typedef struct {
		logic [7:0] data;
		logic       last;
	} reply_t;

	typedef logic [7:0] byte_q_t[$];

	class dns_reply_board;
		logic [31:0] answer_ip;
		logic [3:0]  hdr_count;
		logic [7:0]  hdr [HDR_LEN];
		phase_t      phase;
		reply_t      reply_queue[$];
		int          errors;

		function new();
			answer_ip = '0;
			hdr_count = '0;
			phase = PH_COLLECT;
			errors = 0;
		endfunction

		function void push(logic [7:0] data, logic last);
			reply_t r;
			r.data = data;
			r.last = last;
			reply_queue.push_back(r);
		endfunction

		function void push_answer();
			for (int i = 0; i < 12; i++)
				push(ANSWER_PREFIX[i], 1'b0);
			push(answer_ip[31:24], 1'b0);
			push(answer_ip[23:16], 1'b0);
			push(answer_ip[15:8], 1'b0);
			push(answer_ip[7:0], 1'b1);
		endfunction

		function bit header_passes();
			bit ok;
			ok = (hdr[2][7] == 1'b0) && (hdr[2][6:3] == 4'd0) &&
				(hdr[4] == 8'd0) && (hdr[5] == 8'd1);
			for (int i = 6; i < HDR_LEN; i++)
				if (hdr[i] != 8'd0)
					ok = 0;
			return ok;
		endfunction

		function void note_request(logic [7:0] data, logic last);
			logic [7:0] h;
			if (phase == PH_COLLECT) begin
				if (hdr_count < HDR_LEN) begin
					hdr[hdr_count] = data;
					hdr_count++;
				end
				if (hdr_count >= HDR_LEN) begin
					if (header_passes()) begin
						for (int i = 0; i < HDR_LEN; i++) begin
							h = hdr[i];
							case (i)
								2: h = h | QR_BIT;
								3: h = h & RA_CLEAR;
								6: h = hdr[4];
								7: h = hdr[5];
								default: ;
							endcase
							push(h, 1'b0);
						end
						phase = PH_ECHO;
					end else begin
						phase = PH_DROP;
					end
					if (last && phase == PH_ECHO)
						push_answer();
				end
			end else if (phase == PH_ECHO) begin
				push(data, 1'b0);
				if (last)
					push_answer();
			end
			if (last) begin
				hdr_count = '0;
				phase = PH_COLLECT;
			end
		endfunction

		function void check_reply(logic [7:0] data, logic last);
			reply_t exp;
			if (reply_queue.size() == 0) begin
				$display("%0t: unexpected reply byte %h last %b", $time, data, last);
				errors++;
				return;
			end
			exp = reply_queue.pop_front();
			if (data !== exp.data) begin
				$display("%0t: out_byte expected %h actual %h", $time, exp.data, data);
				errors++;
			end
			if (last !== exp.last) begin
				$display("%0t: out_last expected %b actual %b", $time, exp.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'd0;
	logic        in_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        out_last;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = 32'd0;

	int send_idle = 31;
	int recv_idle = 55;
	dns_reply_board board = new();

	captive_dns_responder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_reply(out_byte, out_last);
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic send_byte(input logic [7:0] data, input logic last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= data;
		in_last <= last;
		do
			@(posedge clk);
		while (in_stall);
		board.note_request(data, last);
	endtask

	task automatic send_request(input byte_q_t pkt);
		foreach (pkt[i])
			send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (board.reply_queue.size() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		if (board.reply_queue.size() != 0) begin
			$display("%0t: %0d reply bytes never arrived", $time, board.reply_queue.size());
			board.errors++;
			board.reply_queue.delete();
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_answer_ip(input logic [31:0] ip);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ip;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.answer_ip = ip;
	endtask

	function automatic byte_q_t good_header();
		byte_q_t h;
		h.push_back(8'($urandom_range(255)));
		h.push_back(8'($urandom_range(255)));
		h.push_back({5'd0, 3'($urandom_range(7))});
		h.push_back(8'($urandom_range(255)));
		h.push_back(8'd0);
		h.push_back(8'd1);
		repeat (6) h.push_back(8'd0);
		return h;
	endfunction

	task automatic send_random_requests(input int budget);
		byte_q_t pkt;
		int sent;
		int kind;
		sent = 0;
		while (sent < budget) begin
			pkt = good_header();
			kind = $urandom_range(99);
			if (kind < 68) begin
				repeat ($urandom_range(20)) pkt.push_back(8'($urandom_range(255)));
			end else if (kind < 82) begin
				case ($urandom_range(4))
					0: pkt[2][7] = 1'b1;
					1: pkt[2][6:3] = 4'($urandom_range(1, 15));
					2: pkt[4] = 8'($urandom_range(1, 255));
					3: pkt[5] = $urandom_range(1) ? 8'd0 : 8'($urandom_range(2, 255));
					default: pkt[$urandom_range(6, 11)] = 8'($urandom_range(1, 255));
				endcase
				repeat ($urandom_range(5)) pkt.push_back(8'($urandom_range(255)));
			end else if (kind < 92) begin
				pkt = pkt[0:$urandom_range(10)];
			end else begin
				foreach (pkt[i])
					pkt[i] = 8'($urandom_range(255));
				repeat ($urandom_range(4)) pkt.push_back(8'($urandom_range(255)));
			end
			send_request(pkt);
			sent += pkt.size();
		end
	endtask

	initial begin
		byte_q_t pkt;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short request
		pkt = '{8'hFF};
		send_request(pkt);
		// header only, extreme flags kept apart from qr and opcode
		pkt = '{8'hFF, 8'hFF, 8'h07, 8'hFF, 8'h00, 8'h01,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_request(pkt);
		// one name byte echoed
		pkt = '{8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h01,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
		send_request(pkt);
		// qr set, dropped
		pkt = '{8'h12, 8'h34, 8'h80, 8'h00, 8'h00, 8'h01,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_request(pkt);

		drain();
		write_answer_ip(32'hFFFF_FFFF);
		send_random_requests(100);

		drain();
		send_idle = 55;
		recv_idle = 31;
		write_answer_ip($urandom());
		send_random_requests(100);

		drain();
		send_idle = 0;
		recv_idle = 0;
		write_answer_ip(32'h0000_0000);
		send_random_requests(100);

		drain();
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== captive_dns_responder.f =====
+incdir+hdl
hdl/cdr_pkg.sv
hdl/cdr_parse.sv
hdl/cdr_emit.sv
hdl/captive_dns_responder.sv
verif/tb_captive_dns_responder.sv
